// File: hdl/srint_pkg.sv
// Shared types, widths and helpers for the segment / rectangle intersection unit.
// Depends on nothing; the other files in hdl/ except srint_rsp_if use it by scoped names.
package srint_pkg;

	// Field width on the channels and working coordinate width
	localparam int FieldBits = 16;
	localparam int CoordBits = 16;
	// A difference of two coordinates, its products and their sums
	localparam int DiffBits  = CoordBits + 1;
	localparam int ProdBits  = 2 * DiffBits;
	localparam int SumBits   = ProdBits + 1;

	typedef logic signed [FieldBits-1:0] field_t;
	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [DiffBits-1:0]  diff_t;
	typedef logic signed [ProdBits-1:0]  prod_t;
	typedef logic signed [SumBits-1:0]   sum_t;

	// One request, already cut to the working coordinate width
	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
		coord_t c1x;
		coord_t c1y;
		coord_t c2x;
		coord_t c2y;
	} query_t;

	// Offsets of the start point from the box sides, segment direction
	typedef struct packed {
		diff_t ex_lo;    // ax - xlo
		diff_t ex_hi;    // ax - xhi
		diff_t ey_lo;    // ay - ylo
		diff_t ey_hi;    // ay - yhi
		diff_t rx;
		diff_t ry;
		diff_t rx_mag;
		diff_t ry_mag;
		logic  rx_neg;
		logic  ry_neg;
		logic  hz_ok;    // horizontal sides can be crossed (not parallel, not flat)
		logic  vt_ok;    // vertical sides can be crossed
		logic  in_box;   // both endpoints in the closed box
	} geom_t;

	// Products for the four side tests plus parameter range flags
	typedef struct packed {
		prod_t ax_lo;    // ex_lo * |ry|
		prod_t ax_hi;    // ex_hi * |ry|
		prod_t py_hi;    // ey_hi * rx
		prod_t py_lo;    // ey_lo * rx
		prod_t ay_lo;    // ey_lo * |rx|
		prod_t ay_hi;    // ey_hi * |rx|
		prod_t px_lo;    // ex_lo * ry
		prod_t px_hi;    // ex_hi * ry
		logic  t_top;
		logic  t_bot;
		logic  t_left;
		logic  t_right;
		logic  rx_neg;
		logic  ry_neg;
		logic  hz_ok;
		logic  vt_ok;
		logic  in_box;
	} prods_t;

	// Per-stage load enables from the pipeline control
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Keep the low CoordBits bits of a field, sign-extended
	function automatic coord_t to_coord(input field_t v);
		return coord_t'(v);
	endfunction

endpackage

// File: hdl/srint_req_if.sv
// Request channel of the intersection unit: valid/ready plus the query fields.
// Depends on srint_pkg.
interface srint_req_if;
	logic                valid;
	logic                ready;
	srint_pkg::field_t   seg_start_x;
	srint_pkg::field_t   seg_start_y;
	srint_pkg::field_t   seg_end_x;
	srint_pkg::field_t   seg_end_y;
	srint_pkg::field_t   corner_one_x;
	srint_pkg::field_t   corner_one_y;
	srint_pkg::field_t   corner_two_x;
	srint_pkg::field_t   corner_two_y;

	modport source (
		output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		       corner_one_x, corner_one_y, corner_two_x, corner_two_y,
		input  ready
	);
	modport sink (
		input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		       corner_one_x, corner_one_y, corner_two_x, corner_two_y,
		output ready
	);
endinterface

// File: hdl/srint_rsp_if.sv
// Response channel of the intersection unit: valid/ready plus the one-bit answer.
// Self-contained.
interface srint_rsp_if;
	logic valid;
	logic ready;
	logic intersects;

	modport source (output valid, intersects, input ready);
	modport sink (input valid, intersects, output ready);
endinterface

// File: hdl/segment_rectangle_intersect_unit.sv
// Segment / rectangle intersection unit, top level: pipeline control and stage wiring.
// Depends on srint_pkg, srint_req_if, srint_rsp_if, srint_setup, srint_mult, srint_resolve.
//
// Answers whether a segment touches or lies inside an axis-aligned closed rectangle
// given by two opposite corners in any order. A request is taken every cycle unless
// the pipe is stalled, and its answer passes one register stage each for corner
// ordering, side offsets, one rank of 17x17-bit multipliers, and the final span compare.
// All arithmetic is exact; a segment parallel to a side never counts as crossing it.
// Each stage holds its request while the next one is full and cannot move on, so
// backpressure on the response side stalls the pipe without losing or repeating a request.
module segment_rectangle_intersect_unit (
	input  logic              clk,
	input  logic              arst_n,
	srint_req_if.sink         req,
	srint_rsp_if.source       rsp
);

	srint_pkg::stage_en_t en;
	srint_pkg::query_t    query;
	srint_pkg::geom_t     geom_s2;
	srint_pkg::prods_t    prods_s3;
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic                 intersects_s4;

	// A stage loads when it is empty or its contents move on
	always_comb begin
		en.s4 = !v_s4 || rsp.ready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign req.ready      = en.s1;
	assign rsp.valid      = v_s4;
	assign rsp.intersects = intersects_s4;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= req.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	// Cut request fields to the working width
	always_comb begin
		query.ax  = srint_pkg::to_coord(req.seg_start_x);
		query.ay  = srint_pkg::to_coord(req.seg_start_y);
		query.bx  = srint_pkg::to_coord(req.seg_end_x);
		query.by  = srint_pkg::to_coord(req.seg_end_y);
		query.c1x = srint_pkg::to_coord(req.corner_one_x);
		query.c1y = srint_pkg::to_coord(req.corner_one_y);
		query.c2x = srint_pkg::to_coord(req.corner_two_x);
		query.c2y = srint_pkg::to_coord(req.corner_two_y);
	end

	srint_setup u_setup (
		.clk     (clk),
		.en      (en),
		.query   (query),
		.geom_s2 (geom_s2)
	);

	srint_mult u_mult (
		.clk      (clk),
		.en       (en),
		.geom_s2  (geom_s2),
		.prods_s3 (prods_s3)
	);

	srint_resolve u_resolve (
		.clk           (clk),
		.en            (en),
		.prods_s3      (prods_s3),
		.intersects_s4 (intersects_s4)
	);

endmodule

// File: hdl/srint_setup.sv
// Stages 1 and 2: corner ordering, segment direction, side offsets and inside test.
// Depends on srint_pkg.
module srint_setup (
	input  logic                  clk,
	input  srint_pkg::stage_en_t  en,
	input  srint_pkg::query_t     query,
	output srint_pkg::geom_t      geom_s2
);

	localparam int DIFF_MSB = srint_pkg::DiffBits - 1;

	srint_pkg::coord_t ax_s1, ay_s1, bx_s1, by_s1;
	srint_pkg::coord_t xlo_s1, xhi_s1, ylo_s1, yhi_s1;
	srint_pkg::diff_t  rx_s1, ry_s1;

	// Stage 1: order the corners, take the direction vector
	always_ff @(posedge clk) begin
		if (en.s1) begin
			ax_s1  <= query.ax;
			ay_s1  <= query.ay;
			bx_s1  <= query.bx;
			by_s1  <= query.by;
			xlo_s1 <= (query.c1x < query.c2x) ? query.c1x : query.c2x;
			xhi_s1 <= (query.c1x < query.c2x) ? query.c2x : query.c1x;
			ylo_s1 <= (query.c1y < query.c2y) ? query.c1y : query.c2y;
			yhi_s1 <= (query.c1y < query.c2y) ? query.c2y : query.c1y;
			rx_s1  <= srint_pkg::diff_t'(query.bx) - srint_pkg::diff_t'(query.ax);
			ry_s1  <= srint_pkg::diff_t'(query.by) - srint_pkg::diff_t'(query.ay);
		end
	end

	// Stage 2: offsets from each side, magnitudes, degenerate flags
	always_ff @(posedge clk) begin
		if (en.s2) begin
			geom_s2.ex_lo  <= srint_pkg::diff_t'(ax_s1) - srint_pkg::diff_t'(xlo_s1);
			geom_s2.ex_hi  <= srint_pkg::diff_t'(ax_s1) - srint_pkg::diff_t'(xhi_s1);
			geom_s2.ey_lo  <= srint_pkg::diff_t'(ay_s1) - srint_pkg::diff_t'(ylo_s1);
			geom_s2.ey_hi  <= srint_pkg::diff_t'(ay_s1) - srint_pkg::diff_t'(yhi_s1);
			geom_s2.rx     <= rx_s1;
			geom_s2.ry     <= ry_s1;
			geom_s2.rx_mag <= rx_s1[DIFF_MSB] ? -rx_s1 : rx_s1;
			geom_s2.ry_mag <= ry_s1[DIFF_MSB] ? -ry_s1 : ry_s1;
			geom_s2.rx_neg <= rx_s1[DIFF_MSB];
			geom_s2.ry_neg <= ry_s1[DIFF_MSB];
			geom_s2.hz_ok  <= (xhi_s1 != xlo_s1) && (ry_s1 != '0);
			geom_s2.vt_ok  <= (yhi_s1 != ylo_s1) && (rx_s1 != '0);
			geom_s2.in_box <= (ax_s1 >= xlo_s1) && (ax_s1 <= xhi_s1) &&
			                  (bx_s1 >= xlo_s1) && (bx_s1 <= xhi_s1) &&
			                  (ay_s1 >= ylo_s1) && (ay_s1 <= yhi_s1) &&
			                  (by_s1 >= ylo_s1) && (by_s1 <= yhi_s1);
		end
	end

endmodule

// File: hdl/srint_mult.sv
// Stage 3: the eight cross products for the side tests and the crossing-parameter checks.
// Depends on srint_pkg.
module srint_mult (
	input  logic                  clk,
	input  srint_pkg::stage_en_t  en,
	input  srint_pkg::geom_t      geom_s2,
	output srint_pkg::prods_t     prods_s3
);

	// Signed product of two differences, full width
	function automatic srint_pkg::prod_t mul(input srint_pkg::diff_t a,
	                                         input srint_pkg::diff_t b);
		return srint_pkg::prod_t'(a) * srint_pkg::prod_t'(b);
	endfunction

	// Distance to the side line along the segment, sign-corrected, within [0, |r|]
	function automatic logic t_ok(input srint_pkg::diff_t e, input logic neg,
	                              input srint_pkg::diff_t mag);
		srint_pkg::diff_t d;
		d = neg ? e : -e;
		return (d >= 0) && (d <= mag);
	endfunction

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prods_s3.ax_lo   <= mul(geom_s2.ex_lo, geom_s2.ry_mag);
			prods_s3.ax_hi   <= mul(geom_s2.ex_hi, geom_s2.ry_mag);
			prods_s3.py_hi   <= mul(geom_s2.ey_hi, geom_s2.rx);
			prods_s3.py_lo   <= mul(geom_s2.ey_lo, geom_s2.rx);
			prods_s3.ay_lo   <= mul(geom_s2.ey_lo, geom_s2.rx_mag);
			prods_s3.ay_hi   <= mul(geom_s2.ey_hi, geom_s2.rx_mag);
			prods_s3.px_lo   <= mul(geom_s2.ex_lo, geom_s2.ry);
			prods_s3.px_hi   <= mul(geom_s2.ex_hi, geom_s2.ry);
			prods_s3.t_top   <= t_ok(geom_s2.ey_hi, geom_s2.ry_neg, geom_s2.ry_mag);
			prods_s3.t_bot   <= t_ok(geom_s2.ey_lo, geom_s2.ry_neg, geom_s2.ry_mag);
			prods_s3.t_left  <= t_ok(geom_s2.ex_lo, geom_s2.rx_neg, geom_s2.rx_mag);
			prods_s3.t_right <= t_ok(geom_s2.ex_hi, geom_s2.rx_neg, geom_s2.rx_mag);
			prods_s3.rx_neg  <= geom_s2.rx_neg;
			prods_s3.ry_neg  <= geom_s2.ry_neg;
			prods_s3.hz_ok   <= geom_s2.hz_ok;
			prods_s3.vt_ok   <= geom_s2.vt_ok;
			prods_s3.in_box  <= geom_s2.in_box;
		end
	end

endmodule

// File: hdl/srint_resolve.sv
// Stage 4: checks that each side crossing falls within the side's span, forms the answer.
// Depends on srint_pkg.
module srint_resolve (
	input  logic                  clk,
	input  srint_pkg::stage_en_t  en,
	input  srint_pkg::prods_t     prods_s3,
	output logic                  intersects_s4
);

	// Crossing point lies between the two box sides perpendicular to this side:
	// a_lo + c >= 0 and a_hi + c <= 0, where c is +p or -p
	function automatic logic span_ok(input srint_pkg::prod_t a_lo,
	                                 input srint_pkg::prod_t a_hi,
	                                 input srint_pkg::prod_t p, input logic neg);
		srint_pkg::sum_t lo_sum;
		srint_pkg::sum_t hi_sum;
		lo_sum = neg ? srint_pkg::sum_t'(a_lo) + srint_pkg::sum_t'(p)
		             : srint_pkg::sum_t'(a_lo) - srint_pkg::sum_t'(p);
		hi_sum = neg ? srint_pkg::sum_t'(a_hi) + srint_pkg::sum_t'(p)
		             : srint_pkg::sum_t'(a_hi) - srint_pkg::sum_t'(p);
		return (lo_sum >= 0) && (hi_sum <= 0);
	endfunction

	logic hit_top, hit_bot, hit_left, hit_right;

	// Per-side crossing tests
	always_comb begin
		hit_top   = prods_s3.hz_ok && prods_s3.t_top &&
		            span_ok(prods_s3.ax_lo, prods_s3.ax_hi, prods_s3.py_hi, prods_s3.ry_neg);
		hit_bot   = prods_s3.hz_ok && prods_s3.t_bot &&
		            span_ok(prods_s3.ax_lo, prods_s3.ax_hi, prods_s3.py_lo, prods_s3.ry_neg);
		hit_left  = prods_s3.vt_ok && prods_s3.t_left &&
		            span_ok(prods_s3.ay_lo, prods_s3.ay_hi, prods_s3.px_lo, prods_s3.rx_neg);
		hit_right = prods_s3.vt_ok && prods_s3.t_right &&
		            span_ok(prods_s3.ay_lo, prods_s3.ay_hi, prods_s3.px_hi, prods_s3.rx_neg);
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en.s4) begin
			intersects_s4 <= prods_s3.in_box || hit_top || hit_bot || hit_left || hit_right;
		end
	end

endmodule

// File: tb/segment_rectangle_intersect_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for segment_rectangle_intersect_unit: a scoreboard class predicts
// each answer with exact integer geometry. Depends on srint_pkg, srint_req_if, srint_rsp_if.
module segment_rectangle_intersect_unit_tb;

	import srint_pkg::*;

	localparam int PHASE_ITEMS = 560;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 16;

	// One query as it travels on the request channel
	typedef struct {
		field_t sx;
		field_t sy;
		field_t ex;
		field_t ey;
		field_t c1x;
		field_t c1y;
		field_t c2x;
		field_t c2y;
	} seg_query_t;

	// Predicts hit / miss per request and matches answers in order
	class intersect_scoreboard;
		bit expected_hits[$];
		int queries;
		int answers;
		int hits;
		int errors;

		// Segment p + a*r against side q + b*s, closed on both parameters
		function bit side_crossed(longint px, longint py, longint rx, longint ry,
				longint qx, longint qy, longint sx, longint sy);
			longint det;
			longint na;
			longint nb;
			det = ry * sx - rx * sy;
			na = (px - qx) * sy - (py - qy) * sx;
			nb = (px - qx) * ry - (py - qy) * rx;
			// parallel (or zero-length side) never counts
			if (det == 0)
				return 1'b0;
			if (det < 0) begin
				det = -det;
				na = -na;
				nb = -nb;
			end
			return na >= 0 && na <= det && nb >= 0 && nb <= det;
		endfunction

		function bit predict_hit(seg_query_t q);
			longint ax, ay, bx, by, c1x, c1y, c2x, c2y;
			longint xlo, xhi, ylo, yhi, rx, ry;
			ax  = longint'(coord_t'(q.sx));
			ay  = longint'(coord_t'(q.sy));
			bx  = longint'(coord_t'(q.ex));
			by  = longint'(coord_t'(q.ey));
			c1x = longint'(coord_t'(q.c1x));
			c1y = longint'(coord_t'(q.c1y));
			c2x = longint'(coord_t'(q.c2x));
			c2y = longint'(coord_t'(q.c2y));
			xlo = (c1x < c2x) ? c1x : c2x;
			xhi = (c1x < c2x) ? c2x : c1x;
			ylo = (c1y < c2y) ? c1y : c2y;
			yhi = (c1y < c2y) ? c2y : c1y;
			rx = bx - ax;
			ry = by - ay;
			// both endpoints in the closed box
			if (ax >= xlo && ax <= xhi && bx >= xlo && bx <= xhi &&
					ay >= ylo && ay <= yhi && by >= ylo && by <= yhi)
				return 1'b1;
			return side_crossed(ax, ay, rx, ry, xlo, yhi, xhi - xlo, 0) ||
				side_crossed(ax, ay, rx, ry, xhi, yhi, 0, ylo - yhi) ||
				side_crossed(ax, ay, rx, ry, xlo, ylo, 0, yhi - ylo) ||
				side_crossed(ax, ay, rx, ry, xhi, ylo, xlo - xhi, 0);
		endfunction

		function void note_query(seg_query_t q);
			expected_hits.push_back(predict_hit(q));
			queries++;
		endfunction

		function void check_answer(logic actual);
			bit want;
			answers++;
			if (actual === 1'b1)
				hits++;
			if (expected_hits.size() == 0) begin
				$error("intersects: expected none, actual %0b", actual);
				errors++;
				return;
			end
			want = expected_hits.pop_front();
			if (actual !== want) begin
				$error("intersects: expected %0b, actual %0b", want, actual);
				errors++;
			end
		endfunction

		function int pending();
			return expected_hits.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct = 14;
	int   recv_idle_pct = 81;

	intersect_scoreboard board = new();

	srint_req_if req_ch();
	srint_rsp_if rsp_ch();

	segment_rectangle_intersect_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Response side: random ready
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Answers are sampled mid-cycle, where every signal is settled
	always @(negedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			board.check_answer(rsp_ch.intersects);
	end

	// Watchdog: ends the run after too long without any handshake
	initial begin : watchdog
		int stale;
		stale = 0;
		while (stale < STALL_LIMIT) begin
			@(negedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stale = 0;
			else
				stale++;
		end
		$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
		$display("segment_rectangle_intersect_unit_tb: errors");
		$finish;
	end

	// Offer one request, wait for it to be taken
	task automatic send_query(input seg_query_t q);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.seg_start_x  <= q.sx;
		req_ch.seg_start_y  <= q.sy;
		req_ch.seg_end_x    <= q.ex;
		req_ch.seg_end_y    <= q.ey;
		req_ch.corner_one_x <= q.c1x;
		req_ch.corner_one_y <= q.c1y;
		req_ch.corner_two_x <= q.c2x;
		req_ch.corner_two_y <= q.c2y;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = req_ch.ready;
			if (taken)
				board.note_query(q);
			@(posedge clk);
		end
	endtask

	task automatic send_ints(input int sx, input int sy, input int ex, input int ey,
			input int c1x, input int c1y, input int c2x, input int c2y);
		seg_query_t q;
		q.sx  = field_t'(sx);
		q.sy  = field_t'(sy);
		q.ex  = field_t'(ex);
		q.ey  = field_t'(ey);
		q.c1x = field_t'(c1x);
		q.c1y = field_t'(c1y);
		q.c2x = field_t'(c2x);
		q.c2y = field_t'(c2y);
		send_query(q);
	endtask

	// Hold off requests until every answer is back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
	endtask

	function automatic field_t near_coord(input int base, input int spread);
		return field_t'(base + int'($urandom_range(2 * spread)) - spread);
	endfunction

	function automatic field_t extreme_coord();
		int vals[6];
		vals = '{-32768, -32767, -1, 0, 1, 32767};
		return field_t'(vals[$urandom_range(5)]);
	endfunction

	// Mix: full-range noise, tiny grids (touching, parallel, degenerate),
	// segments anchored in a box, axis-aligned runs along sides, extremes
	function automatic seg_query_t random_query();
		seg_query_t q;
		int sel, cx, cy, w, h, lvl;
		sel = $urandom_range(99);
		cx = int'($urandom_range(60000)) - 30000;
		cy = int'($urandom_range(60000)) - 30000;
		w = $urandom_range(500);
		h = $urandom_range(500);
		if ($urandom_range(9) == 0)
			w = 0;
		else if ($urandom_range(9) == 0)
			h = 0;
		if ($urandom_range(1)) begin
			q.c1x = field_t'(cx - w);
			q.c2x = field_t'(cx + w);
		end else begin
			q.c1x = field_t'(cx + w);
			q.c2x = field_t'(cx - w);
		end
		if ($urandom_range(1)) begin
			q.c1y = field_t'(cy - h);
			q.c2y = field_t'(cy + h);
		end else begin
			q.c1y = field_t'(cy + h);
			q.c2y = field_t'(cy - h);
		end
		if (sel < 20) begin
			q.sx  = field_t'($urandom);
			q.sy  = field_t'($urandom);
			q.ex  = field_t'($urandom);
			q.ey  = field_t'($urandom);
			q.c1x = field_t'($urandom);
			q.c1y = field_t'($urandom);
			q.c2x = field_t'($urandom);
			q.c2y = field_t'($urandom);
		end else if (sel < 45) begin
			q.sx  = near_coord(cx, 6);
			q.sy  = near_coord(cy, 6);
			q.ex  = near_coord(cx, 6);
			q.ey  = near_coord(cy, 6);
			q.c1x = near_coord(cx, 4);
			q.c1y = near_coord(cy, 4);
			q.c2x = near_coord(cx, 4);
			q.c2y = near_coord(cy, 4);
		end else if (sel < 75) begin
			q.sx = near_coord(cx, w);
			q.sy = near_coord(cy, h);
			q.ex = near_coord(cx, 3 * w + 10);
			q.ey = near_coord(cy, 3 * h + 10);
			if ($urandom_range(1)) begin
				q.ex = q.sx;
				q.ey = q.sy;
				q.sx = near_coord(cx, 3 * w + 10);
				q.sy = near_coord(cy, 3 * h + 10);
			end
		end else if (sel < 90) begin
			case ($urandom_range(2))
				0: lvl = cy - h;
				1: lvl = cy + h;
				default: lvl = int'(near_coord(cy, h + 3));
			endcase
			if ($urandom_range(1)) begin
				q.sx = near_coord(cx, 2 * w + 5);
				q.ex = near_coord(cx, 2 * w + 5);
				q.sy = field_t'(lvl);
				q.ey = field_t'(lvl);
			end else begin
				lvl = lvl - cy + cx + ($urandom_range(1) ? w - h : h - w);
				q.sy = near_coord(cy, 2 * h + 5);
				q.ey = near_coord(cy, 2 * h + 5);
				q.sx = field_t'(lvl);
				q.ex = field_t'(lvl);
			end
		end else begin
			q.sx  = extreme_coord();
			q.sy  = extreme_coord();
			q.ex  = extreme_coord();
			q.ey  = extreme_coord();
			q.c1x = extreme_coord();
			q.c1y = extreme_coord();
			q.c2x = extreme_coord();
			q.c2y = extreme_coord();
		end
		return q;
	endfunction

	// Stimulus and end of run
	initial begin : stimulus
		int phase;
		int n;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.seg_start_x  = '0;
		req_ch.seg_start_y  = '0;
		req_ch.seg_end_x    = '0;
		req_ch.seg_end_y    = '0;
		req_ch.corner_one_x = '0;
		req_ch.corner_one_y = '0;
		req_ch.corner_two_x = '0;
		req_ch.corner_two_y = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: inside, outside, crossings, corner order, parallel runs,
		// point segments, flat and point boxes, coordinate extremes
		send_ints(2, 2, 8, 8, 0, 0, 10, 10);
		send_ints(20, 20, 30, 25, 0, 0, 10, 10);
		send_ints(5, 5, 15, 5, 0, 0, 10, 10);
		send_ints(-5, 5, 15, 5, 0, 0, 10, 10);
		send_ints(-5, 5, 15, 5, 10, 10, 0, 0);
		send_ints(5, -5, 5, 15, 10, 0, 0, 10);
		send_ints(-5, 10, 15, 10, 0, 0, 10, 10);
		send_ints(12, 0, 20, 0, 0, 0, 10, 10);
		send_ints(2, 10, 8, 10, 0, 10, 10, 0);
		send_ints(4, 4, 4, 4, 0, 0, 10, 10);
		send_ints(11, 4, 11, 4, 0, 0, 10, 10);
		send_ints(10, 10, 10, 10, 0, 0, 10, 10);
		send_ints(10, 10, 15, 15, 0, 0, 10, 10);
		send_ints(11, 10, 15, 5, 0, 0, 10, 10);
		send_ints(0, 5, 10, 5, 5, 0, 5, 10);
		send_ints(5, 0, 5, 10, 0, 5, 10, 5);
		send_ints(0, 0, 10, 10, 5, 5, 5, 5);
		send_ints(-1, 20, 20, -2, 0, 0, 10, 10);
		send_ints(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_ints(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_ints(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_ints(-32768, 32767, 32767, -32768, -1, -1, 0, 0);
		send_ints(32767, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
		send_ints(-32768, 0, -32767, 32767, 32767, 1, -1, 32767);

		// Random: three idle mixes, each with a full drain in the middle
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 81;
				end
				1: begin
					send_idle_pct = 81;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					wait_drained();
				send_query(random_query());
			end
			wait_drained();
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests, %0d answers checked (%0d hits), %0d mismatches,",
			board.queries, board.answers, board.hits, board.errors);
		$display("over directed corner cases and three sender/receiver stall mixes.");
		if (board.errors == 0 && board.pending() == 0)
			$display("segment_rectangle_intersect_unit_tb: clean");
		else
			$display("segment_rectangle_intersect_unit_tb: errors");
		$finish;
	end

endmodule
